// ===== rtl/core/emapos_pkg.sv =====
// Shared types and constants of the encoder motor angle positioner.
`default_nettype none

package emapos_pkg;

    // Counter widths
    localparam int COUNT_WIDTH = 32;
    localparam int DELAY_WIDTH = 16;

    // Field widths
    localparam int RATIO_W = 16;
    localparam int TICK_W  = 16;
    localparam int ANGLE_W = 16;
    localparam int POS_W   = 32;
    localparam int CMP_W   = (DELAY_WIDTH > TICK_W) ? DELAY_WIDTH : TICK_W;

    // Scaling: Q8.8 ratio, low 32 bits of the shifted product are kept
    localparam int Q_FRAC = 8;
    localparam int PROD_W = POS_W + Q_FRAC;

    // Division by a full turn: (x >> 3) * ceil(2^35 / 45) >> 35
    localparam int FULL_TURN  = 360;
    localparam int DIV_PRE    = 3;
    localparam int DIV_SHIFT  = 35;
    localparam int DIV_MAG_W  = 30;
    localparam logic [DIV_MAG_W-1:0] DIV_MAGIC = 30'd763549742;
    localparam int DIV_PROD_W = POS_W - DIV_PRE + DIV_MAG_W;
    localparam int QUOT_W     = 24;
    localparam int REM_W      = 9;
    localparam int DIST_W     = 12;

    // Pipeline stages ahead of the result register
    localparam int STAGES = 6;

    // Register reset values
    localparam logic [RATIO_W-1:0] RATIO_RESET  = 16'd256;
    localparam logic [TICK_W-1:0]  BRAKE_RESET  = 16'd50;
    localparam logic [TICK_W-1:0]  SETTLE_RESET = 16'd100;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEGREE_RATIO = 2'd0,
        CFG_BRAKE_TICKS  = 2'd1,
        CFG_SETTLE_TICKS = 2'd2
    } t_cfg_index;

    // Controller phase
    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_RUN    = 4'b0010,
        PH_BRAKE  = 4'b0100,
        PH_SETTLE = 4'b1000
    } t_phase;

    // Per-item control fields carried down the pipeline
    typedef struct packed {
        logic             tick;
        logic             cmd;
        logic             ang_ok;
        logic [REM_W-1:0] ang;
        logic             mdir;
    } t_ctl;

endpackage

`default_nettype wire

// ===== rtl/core/emapos_sample_if.sv =====
// Input channel: one encoder and command sample per item.
`default_nettype none

interface emapos_sample_if import emapos_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               enc_a;
    logic               enc_b;
    logic               time_tick;
    logic               cmd_valid;
    logic [ANGLE_W-1:0] cmd_angle;

    modport source (output valid, enc_a, enc_b, time_tick, cmd_valid, cmd_angle,
                    input ready);
    modport sink   (input valid, enc_a, enc_b, time_tick, cmd_valid, cmd_angle,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/emapos_result_if.sv =====
// Output channel: drive levels, status and position per item.
`default_nettype none

interface emapos_result_if import emapos_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    drive_fwd;
    logic                    drive_back;
    logic                    busy_res;
    logic signed [POS_W-1:0] position;
    logic                    cmd_rejected;

    modport source (output valid, drive_fwd, drive_back, busy_res, position,
                    cmd_rejected, input ready);
    modport sink   (input valid, drive_fwd, drive_back, busy_res, position,
                    cmd_rejected, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/emapos_cfg_if.sv =====
// Configuration write channel: register index and write data.
`default_nettype none

interface emapos_cfg_if import emapos_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [RATIO_W-1:0]   wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/encoder_motor_angle_positioner_core.sv =====
// Quadrature encoder position controller with go-to-angle commands.
//
// Channels: i_sample takes one item per pin sample (encoder A and B levels,
// timebase tick, optional angle command). o_result gives exactly one item per
// sample: drive pin levels, busy flag, scaled position and a reject flag.
// i_cfg writes the ratio, brake and settle registers; it is always ready. The
// user must write it only while no items are in flight; the block does not enforce this.
// Throughput: one item per clock while the receiver takes results. An accepted
// item passes the register chain count -> magnitude -> scaling multiply ->
// sign -> divide-by-full-turn multiply -> goal -> phase before its result is valid.
// The phase logic keeps its state in the result stage, so back-to-back
// items each see the state left by the one before.
// Reset (synchronous, active low) clears the count, the phase and all stages,
// and loads the register defaults (ratio 1.0, brake 50, settle 100 ticks).
// When the receiver stalls, the result register holds and stages fill up
// from the back; i_sample.ready falls only when every stage is occupied.
`default_nettype none

module encoder_motor_angle_positioner_core import emapos_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    emapos_sample_if.sink   i_sample,
    emapos_result_if.source o_result,
    emapos_cfg_if.sink      i_cfg
);

    // Configuration registers
    logic [RATIO_W-1:0] r_ratio;
    logic [TICK_W-1:0]  r_brake;
    logic [TICK_W-1:0]  r_settle;

    // Encoder state
    logic [COUNT_WIDTH-1:0] r_pulse_count, n_pulse_count;
    logic                   r_mdir, n_mdir;
    logic                   r_last_a;

    // Controller state
    t_phase                  r_phase, n_phase;
    logic signed [POS_W-1:0] r_goal, n_goal;
    logic                    r_run_dir, n_run_dir;
    logic [DELAY_WIDTH-1:0]  r_wait, n_wait;

    // Pipeline handshake
    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] st_free;
    logic [STAGES-1:0] st_load;
    logic              out_free;
    logic              out_load;
    logic              in_accept;
    t_ctl              r_ctl [STAGES];
    t_ctl              in_ctl;

    // Stage payloads
    logic [COUNT_WIDTH-1:0]  r_s1_count;
    logic [COUNT_WIDTH-1:0]  r_s2_mag;
    logic                    r_s2_neg;
    logic [POS_W-1:0]        r_s3_q;
    logic                    r_s3_neg;
    logic signed [POS_W-1:0] r_s4_pos;
    logic [POS_W-1:0]        r_s4_abs;
    logic signed [POS_W-1:0] r_s5_pos;
    logic [REM_W-1:0]        r_s5_abs_lo;
    logic [QUOT_W-1:0]       r_s5_quot;
    logic signed [POS_W-1:0] r_s6_pos;
    logic signed [POS_W-1:0] r_s6_goal;
    logic                    r_s6_rdir;
    logic                    r_s6_go;

    // Result register
    logic                    r_out_vld;
    logic                    r_out_fwd, n_out_fwd;
    logic                    r_out_back, n_out_back;
    logic                    r_out_busy, n_out_busy;
    logic signed [POS_W-1:0] r_out_pos;
    logic                    r_out_rej, n_out_rej;

    // Combinational stage results
    logic [COUNT_WIDTH-1:0]  s2_mag;
    logic [PROD_W-1:0]       s3_prod;
    logic [POS_W-1:0]        s4_negq;
    logic signed [POS_W-1:0] s4_pos;
    logic [POS_W-1:0]        s4_abs;
    logic [DIV_PROD_W-1:0]   s5_prod;
    logic [REM_W-1:0]        s6_rem_u;
    logic signed [DIST_W-1:0] s6_rem, s6_ang, s6_dfw, s6_dbk;
    logic                    s6_up;
    logic                    s6_fwd_pick;
    logic signed [POS_W-1:0] s6_goal;

    // ---------------------------------------------------------------
    // Handshake: a stage takes an item when empty or when it drains
    // ---------------------------------------------------------------
    assign out_free = !r_out_vld || o_result.ready;
    assign out_load = out_free && r_vld[STAGES-1];

    always_comb begin
        st_free[STAGES-1] = !r_vld[STAGES-1] || out_free;
        for (int k = STAGES - 2; k >= 0; k--) begin
            st_free[k] = !r_vld[k] || st_free[k+1];
        end
        st_load[0] = st_free[0] && i_sample.valid;
        for (int k = 1; k < STAGES; k++) begin
            st_load[k] = st_free[k] && r_vld[k-1];
        end
    end

    assign i_sample.ready = st_free[0];
    assign in_accept      = st_load[0];
    assign i_cfg.ready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (st_free[0]) begin
                r_vld[0] <= i_sample.valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (st_free[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (out_free) begin
                r_out_vld <= r_vld[STAGES-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Configuration writes
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio  <= RATIO_RESET;
            r_brake  <= BRAKE_RESET;
            r_settle <= SETTLE_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.reg_index)
                CFG_DEGREE_RATIO: r_ratio  <= i_cfg.wdata;
                CFG_BRAKE_TICKS:  r_brake  <= i_cfg.wdata;
                CFG_SETTLE_TICKS: r_settle <= i_cfg.wdata;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: step the pulse count on a change of channel A
    // ---------------------------------------------------------------
    always_comb begin
        n_mdir        = r_mdir;
        n_pulse_count = r_pulse_count;
        if (i_sample.enc_a != r_last_a) begin
            // equal levels mean forward, which counts down
            n_mdir = (i_sample.enc_a != i_sample.enc_b);
            n_pulse_count = n_mdir ? r_pulse_count + COUNT_WIDTH'(1)
                                   : r_pulse_count - COUNT_WIDTH'(1);
        end
    end

    always_comb begin
        in_ctl.tick   = i_sample.time_tick;
        in_ctl.cmd    = i_sample.cmd_valid;
        in_ctl.ang_ok = i_sample.cmd_angle < ANGLE_W'(FULL_TURN);
        in_ctl.ang    = i_sample.cmd_angle[REM_W-1:0];
        in_ctl.mdir   = n_mdir;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_count <= '0;
            r_mdir        <= 1'b1;
            r_last_a      <= 1'b0;
        end else if (in_accept) begin
            r_pulse_count <= n_pulse_count;
            r_mdir        <= n_mdir;
            r_last_a      <= i_sample.enc_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_count <= n_pulse_count;
        end
    end

    // Carry the control fields alongside the payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_ctl[0] <= in_ctl;
        end
        for (int k = 1; k < STAGES; k++) begin
            if (st_load[k]) begin
                r_ctl[k] <= r_ctl[k-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: magnitude of the count
    // ---------------------------------------------------------------
    assign s2_mag = r_s1_count[COUNT_WIDTH-1] ? COUNT_WIDTH'(0) - r_s1_count : r_s1_count;

    always_ff @(posedge i_clk) begin
        if (st_load[1]) begin
            r_s2_mag <= s2_mag;
            r_s2_neg <= r_s1_count[COUNT_WIDTH-1];
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: scale by the Q8.8 ratio, keep 32 bits above the point
    // ---------------------------------------------------------------
    assign s3_prod = PROD_W'(r_s2_mag) * PROD_W'(r_ratio);

    always_ff @(posedge i_clk) begin
        if (st_load[2]) begin
            r_s3_q   <= s3_prod[PROD_W-1:Q_FRAC];
            r_s3_neg <= r_s2_neg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: apply the sign and form the absolute position
    // ---------------------------------------------------------------
    assign s4_negq = POS_W'(0) - r_s3_q;
    assign s4_pos  = r_s3_neg ? s4_negq : r_s3_q;
    assign s4_abs  = (s4_pos[POS_W-1] == r_s3_neg) ? r_s3_q : s4_negq;

    always_ff @(posedge i_clk) begin
        if (st_load[3]) begin
            r_s4_pos <= s4_pos;
            r_s4_abs <= s4_abs;
        end
    end

    // ---------------------------------------------------------------
    // Stage 5: whole turns by reciprocal multiply
    // ---------------------------------------------------------------
    assign s5_prod = DIV_PROD_W'(r_s4_abs >> DIV_PRE) * DIV_PROD_W'(DIV_MAGIC);

    always_ff @(posedge i_clk) begin
        if (st_load[4]) begin
            r_s5_pos    <= r_s4_pos;
            r_s5_abs_lo <= r_s4_abs[REM_W-1:0];
            r_s5_quot   <= s5_prod[DIV_SHIFT+QUOT_W-1:DIV_SHIFT];
        end
    end

    // ---------------------------------------------------------------
    // Stage 6: nearest matching angle and the shorter way to it
    // ---------------------------------------------------------------
    always_comb begin
        // remainder stays below a full turn, so nine bits are enough
        s6_rem_u = r_s5_abs_lo - REM_W'(r_s5_quot[REM_W-1:0] * REM_W'(FULL_TURN));
        s6_rem   = r_s5_pos[POS_W-1] ? DIST_W'(0) - DIST_W'(s6_rem_u)
                                     : DIST_W'(s6_rem_u);
        s6_ang   = DIST_W'(r_ctl[4].ang);
        s6_up    = s6_ang > s6_rem;
        if (s6_up) begin
            s6_dfw = s6_rem + DIST_W'(FULL_TURN) - s6_ang;
            s6_dbk = s6_ang - s6_rem;
        end else begin
            s6_dfw = s6_rem - s6_ang;
            s6_dbk = DIST_W'(FULL_TURN) + s6_ang - s6_rem;
        end
        // ties go backward
        s6_fwd_pick = s6_dfw < s6_dbk;
        s6_goal = s6_fwd_pick ? r_s5_pos - POS_W'(s6_dfw) : r_s5_pos + POS_W'(s6_dbk);
    end

    always_ff @(posedge i_clk) begin
        if (st_load[5]) begin
            r_s6_pos  <= r_s5_pos;
            r_s6_goal <= s6_goal;
            r_s6_rdir <= !s6_fwd_pick;
            r_s6_go   <= s6_ang != s6_rem;
        end
    end

    // ---------------------------------------------------------------
    // Result stage: run, brake and settle sequencing
    // ---------------------------------------------------------------
    always_comb begin
        t_ctl ctl;
        logic reached;
        ctl        = r_ctl[STAGES-1];
        n_phase    = r_phase;
        n_goal     = r_goal;
        n_run_dir  = r_run_dir;
        n_wait     = r_wait;
        n_out_rej  = 1'b0;
        reached    = 1'b0;

        // start a move from idle
        if (n_phase == PH_IDLE && ctl.cmd) begin
            if (!ctl.ang_ok) begin
                n_out_rej = 1'b1;
            end else if (r_s6_go) begin
                n_run_dir = r_s6_rdir;
                n_goal    = r_s6_goal;
                n_phase   = PH_RUN;
            end
        end

        // stop once the goal is reached or passed
        if (n_phase == PH_RUN) begin
            reached = n_run_dir ? (r_s6_pos >= n_goal) : (r_s6_pos <= n_goal);
            if (reached) begin
                n_phase   = PH_BRAKE;
                n_run_dir = !ctl.mdir;
                n_wait    = '0;
            end
        end

        // reverse drive for the brake time
        if (n_phase == PH_BRAKE) begin
            if (r_phase == PH_BRAKE && ctl.tick && n_wait != '1) begin
                n_wait = n_wait + DELAY_WIDTH'(1);
            end
            if (CMP_W'(n_wait) >= CMP_W'(r_brake) || n_wait == '1) begin
                n_phase = PH_SETTLE;
                n_wait  = '0;
            end
        end

        // both drives low for the settle time
        if (n_phase == PH_SETTLE) begin
            if (r_phase == PH_SETTLE && ctl.tick && n_wait != '1) begin
                n_wait = n_wait + DELAY_WIDTH'(1);
            end
            if (CMP_W'(n_wait) >= CMP_W'(r_settle) || n_wait == '1) begin
                n_phase = PH_IDLE;
                n_wait  = '0;
            end
        end

        n_out_fwd  = (n_phase == PH_RUN || n_phase == PH_BRAKE) && !n_run_dir;
        n_out_back = (n_phase == PH_RUN || n_phase == PH_BRAKE) && n_run_dir;
        n_out_busy = n_phase != PH_IDLE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_goal    <= '0;
            r_run_dir <= 1'b0;
            r_wait    <= '0;
        end else if (out_load) begin
            r_phase   <= n_phase;
            r_goal    <= n_goal;
            r_run_dir <= n_run_dir;
            r_wait    <= n_wait;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_fwd  <= n_out_fwd;
            r_out_back <= n_out_back;
            r_out_busy <= n_out_busy;
            r_out_pos  <= r_s6_pos;
            r_out_rej  <= n_out_rej;
        end
    end

    assign o_result.valid        = r_out_vld;
    assign o_result.drive_fwd    = r_out_fwd;
    assign o_result.drive_back   = r_out_back;
    assign o_result.busy_res     = r_out_busy;
    assign o_result.position     = r_out_pos;
    assign o_result.cmd_rejected = r_out_rej;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_drive_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_out_fwd && r_out_back))
        else $error("both drive pins high");

    a_drive_means_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out_fwd || r_out_back)) |-> r_out_busy)
        else $error("drive active while not busy");

    a_reject_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_rej) |-> (!r_out_busy && r_phase == PH_IDLE))
        else $error("command rejected outside idle");

    a_wait_clear_outside_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE || r_phase == PH_RUN) |-> (r_wait == '0))
        else $error("tick counter left running");

    a_count_holds_without_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_accept |=> $stable(r_pulse_count))
        else $error("pulse count moved without an item");

endmodule

`default_nettype wire
